@@ sv/fbt_pkg.sv @@
// Shared constants for the first-below-threshold minimum tree block.
`default_nettype none

package fbt_pkg;

   localparam int LEAVES_DEFAULT     = 1024;
   localparam int VALUE_BITS_DEFAULT = 30;

   localparam int MODE_W      = 2;
   localparam int INDEX_W     = 10;
   localparam int VALUE_W     = 30;
   localparam int THRESHOLD_W = 32;

   localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;

endpackage

`default_nettype wire

@@ sv/first_below_threshold_min_tree.sv @@
// Minimum tree over a table of values, answering leftmost-index-at-most-threshold queries.
//
// A word on the req_ channel carries a mode, an index, a value, a range and a threshold.
// A load writes the value at the index, a remove marks the index removed, and a query
// returns the leftmost live index in [req_range_low, req_range_high] whose value is at
// most req_threshold. Every word gets exactly one rsp_ word (found, found_index); loads,
// removes and unknown modes answer found 0, index 0.
// The tree lives in one synchronous memory of 2*T entries, T being LEAVES rounded up to a
// power of two, with log2(T) levels. A load or remove walks from the leaf to the root, one
// level per cycle. A query climbs from the low leaf and descends to the first match, one
// node read per cycle. One word is worked on at a time.
// After reset a clearing pass writes every node as removed; req_ready stays low meanwhile.
// Results sit in an output register, so a new word is accepted while a result waits.
// If the receiver stalls with a result held, the next word runs to completion and then
// waits until the output register is free.
`default_nettype none

module first_below_threshold_min_tree import fbt_pkg::*; #(
   parameter int LEAVES     = LEAVES_DEFAULT,
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [MODE_W-1:0]      req_mode,
   input  wire logic [INDEX_W-1:0]     req_index,
   input  wire logic [VALUE_W-1:0]     req_value,
   input  wire logic [INDEX_W-1:0]     req_range_low,
   input  wire logic [INDEX_W-1:0]     req_range_high,
   input  wire logic [THRESHOLD_W-1:0] req_threshold,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic                        rsp_found,
   output logic [INDEX_W-1:0]          rsp_found_index
);

   localparam int IDX_W = $clog2(LEAVES);
   localparam int AW    = IDX_W + 1;
   localparam int NODES = 2 ** AW;
   localparam int KEY_W = VALUE_BITS + 1;
   localparam int CMP_W = (VALUE_BITS > THRESHOLD_W) ? VALUE_BITS : THRESHOLD_W;

   localparam logic [KEY_W-1:0] GONE_KEY  = {1'b1, {VALUE_BITS{1'b0}}};
   localparam logic [IDX_W-1:0] LAST_LEAF = IDX_W'(LEAVES - 1);
   localparam logic [AW-1:0]    ROOT      = AW'(1);

   localparam logic [2:0] ST_CLR  = 3'd0;
   localparam logic [2:0] ST_IDLE = 3'd1;
   localparam logic [2:0] ST_UPD  = 3'd2;
   localparam logic [2:0] ST_SEEK = 3'd3;
   localparam logic [2:0] ST_DESC = 3'd4;
   localparam logic [2:0] ST_DONE = 3'd5;

   logic [KEY_W-1:0] tree_mem [NODES];

   logic [2:0]             state_ff, state_in;
   logic [AW-1:0]          cur_ff, cur_in;
   logic [KEY_W-1:0]       key_ff, key_in;
   logic [IDX_W-1:0]       hi_ff, hi_in;
   logic [THRESHOLD_W-1:0] thr_ff, thr_in;
   logic [MODE_W-1:0]      mode_ff, mode_in;
   logic [AW-1:0]          clr_ff, clr_in;
   logic                   pend_found_ff, pend_found_in;
   logic [INDEX_W-1:0]     pend_index_ff, pend_index_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_found_ff, rsp_found_in;
   logic [INDEX_W-1:0]     rsp_index_ff, rsp_index_in;
   logic [KEY_W-1:0]       rd_ff;

   logic                   mem_we;
   logic [AW-1:0]          mem_waddr;
   logic [KEY_W-1:0]       mem_wdata;
   logic [AW-1:0]          mem_raddr;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         tree_mem[mem_waddr] <= mem_wdata;
      end
      rd_ff <= tree_mem[mem_raddr];
   end

   always_comb begin
      logic [31:0]      idx32;
      logic [31:0]      lo32;
      logic [31:0]      hi32;
      logic [63:0]      val64;
      logic [IDX_W-1:0] hi_clip;
      logic [AW-1:0]    leaf_node;
      logic [AW-1:0]    lo_node;
      logic [KEY_W-1:0] load_key;
      logic             rd_match;
      logic [KEY_W-1:0] pkey;
      logic [AW-1:0]    parent;
      logic [AW-1:0]    up_node;
      logic [AW-1:0]    pick;
      logic [IDX_W-1:0] leaf_idx;
      int               p;

      idx32     = 32'(req_index);
      lo32      = 32'(req_range_low);
      hi32      = 32'(req_range_high);
      val64     = 64'(req_value);
      hi_clip   = (hi32 > 32'(LEAVES - 1)) ? LAST_LEAF : hi32[IDX_W-1:0];
      leaf_node = {1'b1, idx32[IDX_W-1:0]};
      lo_node   = {1'b1, lo32[IDX_W-1:0]};
      load_key  = {1'b0, val64[VALUE_BITS-1:0]};
      rd_match  = !rd_ff[VALUE_BITS] &&
                  (CMP_W'(rd_ff[VALUE_BITS-1:0]) <= CMP_W'(thr_ff));
      pkey      = (rd_ff < key_ff) ? rd_ff : key_ff;
      parent    = cur_ff >> 1;
      p         = AW;
      for (int i = AW - 1; i >= 0; i--) begin
         if (!cur_ff[i]) begin
            p = i;
         end
      end
      up_node   = cur_ff >> p;
      pick      = rd_match ? cur_ff : (cur_ff | AW'(1));
      leaf_idx  = pick[IDX_W-1:0];

      state_in      = state_ff;
      cur_in        = cur_ff;
      key_in        = key_ff;
      hi_in         = hi_ff;
      thr_in        = thr_ff;
      mode_in       = mode_ff;
      clr_in        = clr_ff;
      pend_found_in = pend_found_ff;
      pend_index_in = pend_index_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_index_in  = rsp_index_ff;
      mem_we        = 1'b0;
      mem_waddr     = cur_ff;
      mem_wdata     = key_ff;
      mem_raddr     = cur_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = GONE_KEY;
            clr_in    = clr_ff + AW'(1);
            if (&clr_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               mode_in       = req_mode;
               thr_in        = req_threshold;
               hi_in         = hi_clip;
               pend_found_in = 1'b0;
               pend_index_in = '0;
               state_in      = ST_DONE;
               case (req_mode)
                  MODE_LOAD, MODE_REMOVE: begin
                     if (idx32 < 32'(LEAVES)) begin
                        mem_we    = 1'b1;
                        mem_waddr = leaf_node;
                        mem_wdata = (req_mode == MODE_LOAD) ? load_key : GONE_KEY;
                        key_in    = mem_wdata;
                        cur_in    = leaf_node;
                        mem_raddr = leaf_node ^ AW'(1);
                        state_in  = ST_UPD;
                     end
                  end
                  MODE_QUERY: begin
                     if (lo32 < 32'(LEAVES) && lo32 <= hi32) begin
                        cur_in    = lo_node;
                        mem_raddr = lo_node;
                        state_in  = ST_SEEK;
                     end
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_UPD: begin
            mem_we    = 1'b1;
            mem_waddr = parent;
            mem_wdata = pkey;
            key_in    = pkey;
            cur_in    = parent;
            mem_raddr = parent ^ AW'(1);
            if (parent == ROOT) begin
               state_in = ST_DONE;
            end
         end
         ST_SEEK: begin
            if (rd_match) begin
               if (cur_ff[AW-1]) begin
                  pend_found_in = (cur_ff[IDX_W-1:0] <= hi_ff);
                  pend_index_in = (cur_ff[IDX_W-1:0] <= hi_ff) ?
                                  INDEX_W'(cur_ff[IDX_W-1:0]) : '0;
                  state_in      = ST_DONE;
               end else begin
                  cur_in    = {cur_ff[AW-2:0], 1'b0};
                  mem_raddr = {cur_ff[AW-2:0], 1'b0};
                  state_in  = ST_DESC;
               end
            end else if (up_node == '0) begin
               state_in = ST_DONE;
            end else begin
               cur_in    = up_node | AW'(1);
               mem_raddr = up_node | AW'(1);
            end
         end
         ST_DESC: begin
            if (pick[AW-1]) begin
               pend_found_in = (leaf_idx <= hi_ff);
               pend_index_in = (leaf_idx <= hi_ff) ? INDEX_W'(leaf_idx) : '0;
               state_in      = ST_DONE;
            end else begin
               cur_in    = {pick[AW-2:0], 1'b0};
               mem_raddr = {pick[AW-2:0], 1'b0};
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = pend_found_ff;
               rsp_index_in = pend_index_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff        <= cur_in;
      key_ff        <= key_in;
      hi_ff         <= hi_in;
      thr_ff        <= thr_in;
      mode_ff       <= mode_in;
      pend_found_ff <= pend_found_in;
      pend_index_ff <= pend_index_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_index_ff  <= rsp_index_in;
   end

   assign req_ready       = (state_ff == ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_found_index = rsp_index_ff;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff != ST_IDLE))
      else $error("Accepted word did not start work.");

   a_update_no_found: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && mode_ff != MODE_QUERY) |-> !pend_found_ff)
      else $error("Load or remove produced a found result.");

   a_update_below_root: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPD) |-> (cur_ff[AW-1:1] != '0))
      else $error("Update walk passed the root.");

   a_search_node_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEEK || state_ff == ST_DESC) |-> (cur_ff != '0))
      else $error("Search visited node zero.");

endmodule

`default_nettype wire
